>>> rtl/gmspc_pkg.sv
// ----------------------------------------------------------------------------
// gmspc_pkg
// Types and constants shared by the grid max-score path counter.
// ----------------------------------------------------------------------------
package gmspc_pkg;

    localparam int SCORE_W = 16;
    localparam int COUNT_W = 30;
    localparam int CFG_W   = 8;

    localparam logic [COUNT_W-1:0] COUNT_MOD   = 30'd1000000007;
    localparam logic [SCORE_W-1:0] SCORE_MAX   = 16'hFFFF;
    localparam logic [CFG_W-1:0]   WIDTH_RESET = 8'd128;

    typedef enum logic [1:0] {
        KIND_DIGIT    = 2'd0,
        KIND_START    = 2'd1,
        KIND_OBSTACLE = 2'd2,
        KIND_END      = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0] cell_kind;
        logic [3:0] digit_value;
        logic       last_cell;
    } t_in;

    typedef struct packed {
        logic [SCORE_W-1:0] best_score;
        logic [COUNT_W-1:0] path_count;
    } t_out;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [COUNT_W-1:0] count;
    } t_path;

endpackage

>>> rtl/grid_max_score_path_count.sv
// ----------------------------------------------------------------------------
// grid_max_score_path_count
// Streams grid cells in row-major order and reports the best path score
// and the number of best-score paths at the final cell.
//
// Input channel takes one cell per transfer (kind, digit, last flag).
// Output channel gives one result per grid, on the cell marked last.
// Config channel writes the row width; 0 acts as 1, above MAX_WIDTH as
// MAX_WIDTH. Write it only between grids or while the block is idle.
// Throughput: one cell per cycle unless a config write or a held result
// stalls input; the line store read is registered and prefetched for the
// next column, so cells otherwise flow with no gaps. The result is
// registered and appears in the cycle after the last cell's transfer. After
// a config write, input ready drops while the line store read refreshes.
// Reset: row width 128, position at column 0 of the first row, left and
// diagonal neighbors cleared; input ready rises once r_fresh is set.
// A stalled receiver holds the result; input is still taken until a
// second result would be due.
// ----------------------------------------------------------------------------
module grid_max_score_path_count #(
    parameter int MAX_WIDTH = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gmspc_pkg::t_in    i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gmspc_pkg::t_out   o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [gmspc_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > gmspc_pkg::CFG_W) ?
                        $clog2(MAX_WIDTH + 1) : gmspc_pkg::CFG_W;

    logic [gmspc_pkg::CFG_W-1:0] r_width;
    logic [CW-1:0]               r_col,   n_col;
    logic                        r_first, n_first;
    logic                        r_fresh;
    gmspc_pkg::t_path            r_left,  n_left;
    gmspc_pkg::t_path            r_diag,  n_diag;
    logic                        r_out_vld;
    gmspc_pkg::t_out             r_out;

    logic              in_fire;
    logic              cfg_fire;
    logic [WW-1:0]     eff_w;
    logic [CW-1:0]     eff_col;
    logic              wrap;
    logic [CW-1:0]     rd_addr;
    gmspc_pkg::t_path  rd_data;
    gmspc_pkg::t_path  up;
    gmspc_pkg::t_path  zero_path;
    gmspc_pkg::t_path  acc0, acc1, acc2;
    gmspc_pkg::t_path  cell_val;
    logic [gmspc_pkg::SCORE_W:0] score_sum;
    logic [3:0]        add;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;
    assign o_in_ready  = r_fresh &&
                         (!r_out_vld || i_out_ready || !i_in_data.last_cell);
    assign in_fire     = i_in_valid && o_in_ready;
    assign zero_path   = '0;

    always_comb begin
        if (r_width == '0) begin
            eff_w = WW'(1);
        end else if (WW'(r_width) > WW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_width);
        end
        if (WW'(r_col) >= eff_w) begin
            eff_col = CW'(eff_w - WW'(1));
        end else begin
            eff_col = r_col;
        end
        wrap = (WW'(eff_col) + WW'(1)) >= eff_w;
    end

    assign up = r_first ? zero_path : rd_data;

    gmspc_cell u_cell_left (
        .i_en  (eff_col != '0),
        .i_nbr (r_left),
        .i_acc (zero_path),
        .o_acc (acc0)
    );

    gmspc_cell u_cell_diag (
        .i_en  ((eff_col != '0) && !r_first),
        .i_nbr (r_diag),
        .i_acc (acc0),
        .o_acc (acc1)
    );

    gmspc_cell u_cell_up (
        .i_en  (!r_first),
        .i_nbr (up),
        .i_acc (acc1),
        .o_acc (acc2)
    );

    always_comb begin
        add       = (i_in_data.cell_kind == gmspc_pkg::KIND_DIGIT) ?
                    i_in_data.digit_value : 4'd0;
        score_sum = {1'b0, acc2.score} + (gmspc_pkg::SCORE_W + 1)'(add);
        case (i_in_data.cell_kind)
            gmspc_pkg::KIND_START: begin
                cell_val.score = '0;
                cell_val.count = gmspc_pkg::COUNT_W'(1);
            end
            gmspc_pkg::KIND_OBSTACLE: begin
                cell_val = '0;
            end
            gmspc_pkg::KIND_DIGIT, gmspc_pkg::KIND_END: begin
                if (acc2.count == '0) begin
                    cell_val = '0;
                end else begin
                    cell_val.count = acc2.count;
                    cell_val.score = score_sum[gmspc_pkg::SCORE_W] ?
                                     gmspc_pkg::SCORE_MAX :
                                     score_sum[gmspc_pkg::SCORE_W-1:0];
                end
            end
            default: begin
                cell_val = '0;
            end
        endcase
    end

    always_comb begin
        n_col   = r_col;
        n_first = r_first;
        n_left  = r_left;
        n_diag  = r_diag;
        if (in_fire) begin
            n_left = cell_val;
            n_diag = up;
            if (i_in_data.last_cell) begin
                n_col   = '0;
                n_first = 1'b1;
                n_left  = '0;
                n_diag  = '0;
            end else if (wrap) begin
                n_col   = '0;
                n_first = 1'b0;
            end else begin
                n_col = eff_col + CW'(1);
            end
        end
    end

    assign rd_addr = in_fire ? n_col : eff_col;

    gmspc_line #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (in_fire),
        .i_waddr (eff_col),
        .i_wdata (cell_val),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= gmspc_pkg::WIDTH_RESET;
            r_col     <= '0;
            r_first   <= 1'b1;
            r_fresh   <= 1'b0;
            r_left    <= '0;
            r_diag    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (cfg_fire) begin
                r_width <= i_cfg_data;
            end
            r_fresh <= !cfg_fire;
            r_col   <= n_col;
            r_first <= n_first;
            r_left  <= n_left;
            r_diag  <= n_diag;
            if (in_fire && i_in_data.last_cell) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_in_data.last_cell) begin
            r_out.best_score <= cell_val.score;
            r_out.path_count <= cell_val.count;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> rtl/gmspc_cell.sv
// ----------------------------------------------------------------------------
// gmspc_cell
// One merge cell: folds a neighbor's score and count into the running best.
// ----------------------------------------------------------------------------
module gmspc_cell (
    input  logic              i_en,
    input  gmspc_pkg::t_path  i_nbr,
    input  gmspc_pkg::t_path  i_acc,
    output gmspc_pkg::t_path  o_acc
);

    logic [gmspc_pkg::COUNT_W:0] sum;
    logic [gmspc_pkg::COUNT_W:0] sum_red;

    always_comb begin
        sum = {1'b0, i_acc.count} + {1'b0, i_nbr.count};
        if (sum >= {1'b0, gmspc_pkg::COUNT_MOD}) begin
            sum_red = sum - {1'b0, gmspc_pkg::COUNT_MOD};
        end else begin
            sum_red = sum;
        end
    end

    always_comb begin
        o_acc = i_acc;
        if (i_en && (i_nbr.count != '0)) begin
            if ((i_acc.count == '0) || (i_nbr.score > i_acc.score)) begin
                o_acc = i_nbr;
            end else if (i_nbr.score == i_acc.score) begin
                o_acc.count = sum_red[gmspc_pkg::COUNT_W-1:0];
            end
        end
    end

endmodule

>>> rtl/gmspc_line.sv
// ----------------------------------------------------------------------------
// gmspc_line
// Previous-row line store with registered read and write-to-read bypass.
// ----------------------------------------------------------------------------
module gmspc_line #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  gmspc_pkg::t_path  i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output gmspc_pkg::t_path  o_rdata
);

    gmspc_pkg::t_path r_mem [DEPTH];
    gmspc_pkg::t_path r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
